/* sv/zrxr_pkg.sv */
// ----------------------------------------------------------------------------
// zrxr_pkg: shared types and constants of the zero-run XOR row decoder
// Sequencer states, configuration bundle and fixed field widths.
// ----------------------------------------------------------------------------
package zrxr_pkg;

   // fixed field widths
   localparam int CODE_W    = 8;
   localparam int PIX_W     = 8;
   localparam int CFG_W     = 13;
   localparam int ROW_W     = 12;
   localparam int OUT_COL_W = 12;
   localparam int COUNT_W   = 3;
   // wide enough to compare columns against any width up to 8192
   localparam int CMP_W     = 14;

   // pixels carried by one result and the slot index that walks them
   localparam int GROUP_SIZE = 4;
   localparam int SLOT_W     = $clog2(GROUP_SIZE);

   localparam int MAX_HEIGHT = 4096;

   // register indexes (byte address / 4)
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] DIM_RESET = 13'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MERGE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] height;
      logic             restart;
   } cfg_type;

endpackage

/* sv/zrxr_ram.sv */
// ----------------------------------------------------------------------------
// zrxr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module zrxr_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/zrxr_csr.sv */
// ----------------------------------------------------------------------------
// zrxr_csr: configuration registers of the zero-run XOR row decoder
// APB-style write and read of image width and height, with range clamping.
// ----------------------------------------------------------------------------
module zrxr_csr #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output zrxr_pkg::cfg_type       cfg
);

   logic [zrxr_pkg::CFG_W-1:0] width_ff, width_in;
   logic [zrxr_pkg::CFG_W-1:0] height_ff, height_in;
   logic [zrxr_pkg::CFG_W-1:0] wvalue;
   logic                       wr_hit;

   assign wr_hit = psel & penable & pwrite;
   assign wvalue = pwdata[zrxr_pkg::CFG_W-1:0];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_hit) begin
         case (paddr[2])
            zrxr_pkg::REG_WIDTH: begin
               if (wvalue == '0) begin
                  width_in = zrxr_pkg::CFG_W'(1);
               end else if ({1'b0, wvalue} > (zrxr_pkg::CFG_W + 1)'(MAX_WIDTH)) begin
                  width_in = zrxr_pkg::CFG_W'(MAX_WIDTH);
               end else begin
                  width_in = wvalue;
               end
            end
            zrxr_pkg::REG_HEIGHT: begin
               if (wvalue == '0) begin
                  height_in = zrxr_pkg::CFG_W'(1);
               end else if (wvalue > zrxr_pkg::CFG_W'(zrxr_pkg::MAX_HEIGHT)) begin
                  height_in = zrxr_pkg::CFG_W'(zrxr_pkg::MAX_HEIGHT);
               end else begin
                  height_in = wvalue;
               end
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= zrxr_pkg::DIM_RESET;
         height_ff <= zrxr_pkg::DIM_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (paddr[2])
         zrxr_pkg::REG_WIDTH:  prdata = 32'(width_ff);
         zrxr_pkg::REG_HEIGHT: prdata = 32'(height_ff);
         default:              prdata = '0;
      endcase
   end

   assign cfg.width   = width_ff;
   assign cfg.height  = height_ff;
   assign cfg.restart = wr_hit;

endmodule

/* sv/zero_run_xor_row_decoder.sv */
// ----------------------------------------------------------------------------
// zero_run_xor_row_decoder: zero-run decoder with row XOR delta
// Expands literal and zero-run codes into pixels, XORs each with the pixel
// above from a line store and delivers groups of up to four pixels.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                 payload
//   req_      in         req_valid / req_ready     req_code_byte
//   rsp_      out        rsp_valid / rsp_ready     rsp_pixel_0..3, rsp_pixel_count,
//                                                  rsp_start_column, rsp_row_number,
//                                                  rsp_row_done, rsp_frame_done, rsp_last
//   csr_      in/out     APB-style, pready high    image_width (0x0), image_height (0x4)
//
// A marker or a count byte that yields no pixels leaves the sequencer idle. Each
// pixel passes ST_READ (line store read), then ST_MERGE (XOR and write back on the
// same single port pair), and each group of up to four pixels then waits in the
// result register in ST_EMIT, held there by any rsp_ready stall.
// One transaction at a time: req_ready is high only while the sequencer is idle.
// Row 0 reads the line store as zeros, so no clearing pass is needed after reset,
// a register write or a frame end. Reset is synchronous and active high.
// ----------------------------------------------------------------------------
module zero_run_xor_row_decoder #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_code_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_0,
   output logic [7:0]  rsp_pixel_1,
   output logic [7:0]  rsp_pixel_2,
   output logic [7:0]  rsp_pixel_3,
   output logic [2:0]  rsp_pixel_count,
   output logic [11:0] rsp_start_column,
   output logic [11:0] rsp_row_number,
   output logic        rsp_row_done,
   output logic        rsp_frame_done,
   output logic        rsp_last,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   zrxr_pkg::cfg_type cfg;

   zrxr_pkg::state_type state_ff, state_in;

   logic [COL_W-1:0]                column_ff, column_in;
   logic [zrxr_pkg::ROW_W-1:0]      row_ff, row_in;
   logic                            await_ff, await_in;
   logic [zrxr_pkg::CODE_W-1:0]     remain_ff, remain_in;
   logic [zrxr_pkg::PIX_W-1:0]      literal_ff, literal_in;
   logic [zrxr_pkg::SLOT_W-1:0]     slot_ff, slot_in;

   logic [zrxr_pkg::PIX_W-1:0]      pix_ff [zrxr_pkg::GROUP_SIZE];
   logic [zrxr_pkg::PIX_W-1:0]      pix_in [zrxr_pkg::GROUP_SIZE];
   logic [COL_W-1:0]                start_col_ff, start_col_in;
   logic [zrxr_pkg::ROW_W-1:0]      row_num_ff, row_num_in;
   logic [zrxr_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic                            row_done_ff, row_done_in;
   logic                            frame_done_ff, frame_done_in;
   logic                            last_ff, last_in;

   logic                            req_hit;
   logic [zrxr_pkg::CMP_W-1:0]      room;
   logic [zrxr_pkg::CMP_W-1:0]      col_next;
   logic [zrxr_pkg::PIX_W-1:0]      above;
   logic [zrxr_pkg::PIX_W-1:0]      merged;
   logic                            group_end;

   logic                            ram_wr_en;
   logic                            ram_rd_en;
   logic [zrxr_pkg::PIX_W-1:0]      ram_rd_data;

   zrxr_csr #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   assign csr_pready = 1'b1;

   zrxr_ram #(
      .DATA_W (zrxr_pkg::PIX_W),
      .DEPTH  (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (column_ff),
      .wr_data (merged),
      .rd_en   (ram_rd_en),
      .rd_addr (column_ff),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == zrxr_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == zrxr_pkg::ST_EMIT);
   assign req_hit   = req_valid & req_ready;

   assign room     = zrxr_pkg::CMP_W'(cfg.width) - zrxr_pkg::CMP_W'(column_ff);
   assign col_next = zrxr_pkg::CMP_W'(column_ff) + zrxr_pkg::CMP_W'(1);
   // the first row of a frame sees an all-zero row above it
   assign above    = (row_ff == '0) ? '0 : ram_rd_data;
   assign merged   = above ^ literal_ff;
   assign group_end = (remain_ff == zrxr_pkg::CODE_W'(1)) ||
                      (slot_ff == zrxr_pkg::SLOT_W'(zrxr_pkg::GROUP_SIZE - 1));

   assign ram_rd_en = (state_ff == zrxr_pkg::ST_READ);
   assign ram_wr_en = (state_ff == zrxr_pkg::ST_MERGE);

   always_comb begin
      state_in      = state_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      await_in      = await_ff;
      remain_in     = remain_ff;
      literal_in    = literal_ff;
      slot_in       = slot_ff;
      pix_in        = pix_ff;
      start_col_in  = start_col_ff;
      row_num_in    = row_num_ff;
      count_in      = count_ff;
      row_done_in   = row_done_ff;
      frame_done_in = frame_done_ff;
      last_in       = last_ff;

      case (state_ff)
         zrxr_pkg::ST_IDLE: begin
            slot_in = '0;
            if (req_hit) begin
               if (await_ff) begin
                  await_in   = 1'b0;
                  literal_in = '0;
                  if (zrxr_pkg::CMP_W'(req_code_byte) > room) begin
                     remain_in = zrxr_pkg::CODE_W'(room);
                  end else begin
                     remain_in = req_code_byte;
                  end
                  // a clipped-to-nothing or zero count ends here
                  if ((req_code_byte != '0) && (room != '0)) begin
                     state_in = zrxr_pkg::ST_READ;
                  end
               end else if (req_code_byte == '0) begin
                  await_in = 1'b1;
               end else begin
                  literal_in = req_code_byte;
                  remain_in  = zrxr_pkg::CODE_W'(1);
                  state_in   = zrxr_pkg::ST_READ;
               end
            end
         end

         zrxr_pkg::ST_READ: begin
            state_in = zrxr_pkg::ST_MERGE;
         end

         zrxr_pkg::ST_MERGE: begin
            if (slot_ff == '0) begin
               for (int i = 0; i < zrxr_pkg::GROUP_SIZE; i++) begin
                  pix_in[i] = '0;
               end
               start_col_in = column_ff;
            end
            pix_in[slot_ff] = merged;
            remain_in       = remain_ff - zrxr_pkg::CODE_W'(1);
            if (group_end) begin
               count_in      = zrxr_pkg::COUNT_W'(slot_ff) + zrxr_pkg::COUNT_W'(1);
               row_num_in    = row_ff;
               last_in       = (remain_ff == zrxr_pkg::CODE_W'(1));
               row_done_in   = 1'b0;
               frame_done_in = 1'b0;
               if (col_next >= zrxr_pkg::CMP_W'(cfg.width)) begin
                  row_done_in = 1'b1;
                  column_in   = '0;
                  if ((zrxr_pkg::CFG_W'(row_ff) + zrxr_pkg::CFG_W'(1)) >= cfg.height) begin
                     frame_done_in = 1'b1;
                     row_in        = '0;
                  end else begin
                     row_in = row_ff + zrxr_pkg::ROW_W'(1);
                  end
               end else begin
                  column_in = COL_W'(col_next);
               end
               state_in = zrxr_pkg::ST_EMIT;
            end else begin
               column_in = COL_W'(col_next);
               slot_in   = slot_ff + zrxr_pkg::SLOT_W'(1);
               state_in  = zrxr_pkg::ST_READ;
            end
         end

         zrxr_pkg::ST_EMIT: begin
            slot_in = '0;
            if (rsp_ready) begin
               state_in = last_ff ? zrxr_pkg::ST_IDLE : zrxr_pkg::ST_READ;
            end
         end

         default: begin
            state_in = zrxr_pkg::ST_IDLE;
         end
      endcase

      // a register write restarts the frame
      if (cfg.restart) begin
         state_in  = zrxr_pkg::ST_IDLE;
         column_in = '0;
         row_in    = '0;
         await_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= zrxr_pkg::ST_IDLE;
         column_ff <= '0;
         row_ff    <= '0;
         await_ff  <= 1'b0;
         slot_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         await_ff  <= await_in;
         slot_ff   <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff     <= remain_in;
      literal_ff    <= literal_in;
      pix_ff        <= pix_in;
      start_col_ff  <= start_col_in;
      row_num_ff    <= row_num_in;
      count_ff      <= count_in;
      row_done_ff   <= row_done_in;
      frame_done_ff <= frame_done_in;
      last_ff       <= last_in;
   end

   assign rsp_pixel_0      = pix_ff[0];
   assign rsp_pixel_1      = pix_ff[1];
   assign rsp_pixel_2      = pix_ff[2];
   assign rsp_pixel_3      = pix_ff[3];
   assign rsp_pixel_count  = count_ff;
   assign rsp_start_column = zrxr_pkg::OUT_COL_W'(start_col_ff);
   assign rsp_row_number   = row_num_ff;
   assign rsp_row_done     = row_done_ff;
   assign rsp_frame_done   = frame_done_ff;
   assign rsp_last         = last_ff;

endmodule
